/* rtl/core/inssort_pkg.sv */
// Shared types and constants for the insertion sorter.
package inssort_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

endpackage

/* rtl/core/inssort_cell.sv */
// One cell of the insertion chain: holds one sorted entry and its valid bit.
module inssort_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  inssort_pkg::cell_ctrl_type ctrl,
   input  inssort_pkg::data_type    new_value,
   input  inssort_pkg::data_type    prev_data,
   input  logic                     prev_valid,
   input  logic                     prev_gt,
   input  inssort_pkg::data_type    next_data,
   input  logic                     next_valid,
   output inssort_pkg::data_type    data,
   output logic                     valid,
   output logic                     gt
);

   inssort_pkg::data_type data_ff, data_in;
   logic                  valid_ff, valid_in;

   // empty cells count as greater, so the new item lands after all stored ones <= it
   assign gt = !valid_ff || (data_ff > new_value);

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      priority if (ctrl.shift) begin
         data_in  = next_data;
         valid_in = next_valid;
      end else if (ctrl.insert && gt) begin
         data_in  = prev_gt ? prev_data : new_value;
         valid_in = valid_ff | prev_valid;
      end else begin
         data_in  = data_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

/* rtl/core/insertion_sorter.sv */
// Insertion sorter top level: cell chain and fill/drain control.
//
// Items arrive on the req_ channel (req_value, req_last), one set at a time.
// Each accepted item is inserted into a chain of CAPACITY cells,
// after every stored value less than or equal to it, so equal values keep
// arrival order. Items arriving while the chain is full are dropped and the
// set is marked overflowed. While filling, req_stall is low: one item/cycle.
// The item with req_last high ends the set. From the next cycle the chain
// drains from its head on the rsp_ channel, one result per cycle when the
// receiver does not stall; rsp_final_res marks the largest value and
// rsp_overflow is set on every result of an overflowed set. The first result
// is valid in the cycle after the last item is accepted. req_stall stays high
// during the drain; the cell chain shifts only on an accepted result.
// A stalled result holds in the head cell unchanged. Reset (synchronous)
// empties the chain and returns to filling; stored data is not cleared.
module insertion_sorter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  inssort_pkg::data_type req_value,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output inssort_pkg::data_type rsp_sorted_value,
   output logic                  rsp_final_res,
   output logic                  rsp_overflow
);

   localparam int Cap = inssort_pkg::CAPACITY;

   inssort_pkg::state_type     state_ff, state_in;
   logic                       dropped_ff, dropped_in;
   inssort_pkg::cell_ctrl_type ctrl;
   inssort_pkg::data_type      cell_data [Cap];
   logic [Cap-1:0]             cell_valid;
   logic [Cap-1:0]             cell_gt;
   logic                       req_take, rsp_take, full;

   assign full     = cell_valid[Cap-1];
   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   for (genvar i = 0; i < Cap; i++) begin : g_cell
      inssort_pkg::data_type prev_data, next_data;
      logic                  prev_valid, prev_gt, next_valid;
      if (i == 0) begin : g_head
         assign prev_data  = req_value;
         assign prev_valid = 1'b1;
         assign prev_gt    = 1'b0;
      end else begin : g_body
         assign prev_data  = cell_data[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_gt    = cell_gt[i-1];
      end
      if (i == Cap-1) begin : g_tail
         assign next_data  = '0;
         assign next_valid = 1'b0;
      end else begin : g_inner
         assign next_data  = cell_data[i+1];
         assign next_valid = cell_valid[i+1];
      end
      inssort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_value  (req_value),
         .prev_data  (prev_data),
         .prev_valid (prev_valid),
         .prev_gt    (prev_gt),
         .next_data  (next_data),
         .next_valid (next_valid),
         .data       (cell_data[i]),
         .valid      (cell_valid[i]),
         .gt         (cell_gt[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         inssort_pkg::ST_FILL: begin
            if (req_take && req_last) state_in = inssort_pkg::ST_DRAIN;
         end
         inssort_pkg::ST_DRAIN: begin
            if (rsp_take && rsp_final_res) state_in = inssort_pkg::ST_FILL;
         end
         default: state_in = inssort_pkg::ST_FILL;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      ctrl.insert = 1'b0;
      ctrl.shift  = 1'b0;
      dropped_in  = dropped_ff;
      unique case (state_ff)
         inssort_pkg::ST_FILL: begin
            req_stall   = 1'b0;
            ctrl.insert = req_take && !full;
            if (req_take && full) dropped_in = 1'b1;
         end
         inssort_pkg::ST_DRAIN: begin
            rsp_valid  = cell_valid[0];
            ctrl.shift = rsp_take;
            if (rsp_take && rsp_final_res) dropped_in = 1'b0;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= inssort_pkg::ST_FILL;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_sorted_value = cell_data[0];
   assign rsp_final_res    = cell_valid[0] && !cell_valid[1];
   assign rsp_overflow     = dropped_ff;

   // occupied cells always form an unbroken run from the head
   logic [Cap:0] occ_plus_one;
   assign occ_plus_one = {1'b0, cell_valid} + {{Cap{1'b0}}, 1'b1};

   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      $onehot(occ_plus_one))
      else $error("cell chain has a hole");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      cell_valid[1] |-> (cell_data[0] <= cell_data[1]))
      else $error("head cells out of order");

   a_drop_flag: assert property (@(posedge clock) disable iff (reset)
      (req_take && full) |=> rsp_overflow)
      else $error("dropped item not flagged");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_final_res) |=> (!cell_valid[0] && !rsp_overflow && !req_stall))
      else $error("chain not empty after final result");

endmodule

/* dv/insertion_sorter_test.sv */
// Self-checking testbench for the insertion sorter: directed sets, then random sets.
`timescale 1ns / 100ps

module insertion_sorter_test;

   localparam inssort_pkg::data_type VAL_MAX = 32'sh7FFF_FFFF;
   localparam inssort_pkg::data_type VAL_MIN = 32'sh8000_0000;
   localparam int                    RANDOM_ITEMS = 330;

   typedef struct packed {
      inssort_pkg::data_type sorted_value;
      logic                  final_res;
      logic                  overflow;
   } sorted_rec_type;

   typedef struct packed {
      inssort_pkg::data_type value;
      logic                  last;
      logic                  typed;
      sorted_rec_type        want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   inssort_pkg::data_type req_value = '0;
   logic                  req_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   inssort_pkg::data_type rsp_sorted_value;
   logic                  rsp_final_res;
   logic                  rsp_overflow;

   logic           row_typed = 1'b0;
   sorted_rec_type row_want = '0;
   logic           quiet_phase = 1'b0;
   int             error_count = 0;

   // sorting model state
   inssort_pkg::data_type model_store [inssort_pkg::CAPACITY];
   int                    model_fill = 0;
   logic                  model_dropped = 1'b0;
   sorted_rec_type        pending_sorted [$];

   stim_row_type directed_rows [22] = '{
      '{VAL_MAX, 1'b1, 1'b1, '{VAL_MAX, 1'b1, 1'b0}},
      '{VAL_MIN, 1'b1, 1'b1, '{VAL_MIN, 1'b1, 1'b0}},
      '{32'sd0, 1'b1, 1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{-32'sd1, 1'b1, 1'b1, '{-32'sd1, 1'b1, 1'b0}},
      '{32'sd5, 1'b0, 1'b0, '0},
      '{-32'sd3, 1'b0, 1'b0, '0},
      '{32'sd5, 1'b0, 1'b0, '0},
      '{VAL_MIN, 1'b0, 1'b0, '0},
      '{VAL_MAX, 1'b0, 1'b0, '0},
      '{32'sd0, 1'b0, 1'b0, '0},
      '{-32'sd3, 1'b0, 1'b0, '0},
      '{32'sd7, 1'b1, 1'b0, '0},
      '{32'sd3, 1'b0, 1'b0, '0},
      '{32'sd2, 1'b0, 1'b0, '0},
      '{32'sd1, 1'b0, 1'b0, '0},
      '{32'sd0, 1'b1, 1'b0, '0},
      '{-32'sd2, 1'b0, 1'b0, '0},
      '{-32'sd1, 1'b0, 1'b0, '0},
      '{32'sd1, 1'b0, 1'b0, '0},
      '{32'sd2, 1'b1, 1'b0, '0},
      '{32'sh5555_5555, 1'b0, 1'b0, '0},
      '{32'shAAAA_AAAA, 1'b1, 1'b0, '0}
   };

   insertion_sorter DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res),
      .rsp_overflow     (rsp_overflow)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // stable insertion: new value goes after every stored value <= it
   function automatic void sort_insert(inssort_pkg::data_type v);
      int pos;
      pos = 0;
      if (model_fill >= inssort_pkg::CAPACITY) begin
         model_dropped = 1'b1;
         return;
      end
      while (pos < model_fill && model_store[pos] <= v) pos++;
      for (int k = model_fill; k > pos; k--) model_store[k] = model_store[k-1];
      model_store[pos] = v;
      model_fill++;
   endfunction

   function automatic void accept_item(inssort_pkg::data_type v, logic l, logic t,
                                       sorted_rec_type w);
      sorted_rec_type rec;
      sort_insert(v);
      if (!l) return;
      if (t) begin
         pending_sorted.push_back(w);
      end else begin
         for (int k = 0; k < model_fill; k++) begin
            rec.sorted_value = model_store[k];
            rec.final_res    = (k == model_fill - 1);
            rec.overflow     = model_dropped;
            pending_sorted.push_back(rec);
         end
      end
      model_fill    = 0;
      model_dropped = 1'b0;
   endfunction

   function automatic void check_sorted(inssort_pkg::data_type v, logic f, logic o);
      sorted_rec_type exp_rec;
      if (pending_sorted.size() == 0) begin
         $error("unexpected item: sorted_value %0d", v);
         error_count++;
         return;
      end
      exp_rec = pending_sorted.pop_front();
      if (v !== exp_rec.sorted_value) begin
         $error("sorted_value: expected %0d, actual %0d", exp_rec.sorted_value, v);
         error_count++;
      end
      if (f !== exp_rec.final_res) begin
         $error("final_res: expected %0b, actual %0b", exp_rec.final_res, f);
         error_count++;
      end
      if (o !== exp_rec.overflow) begin
         $error("overflow: expected %0b, actual %0b", exp_rec.overflow, o);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) accept_item(req_value, req_last, row_typed, row_want);
         if (rsp_valid && !rsp_stall) check_sorted(rsp_sorted_value, rsp_final_res, rsp_overflow);
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !quiet_phase && ($urandom_range(0, 99) < 10);
   end

   function automatic inssort_pkg::data_type random_value();
      unique case ($urandom_range(0, 9))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2, 3: return inssort_pkg::data_type'($urandom_range(0, 15)) - 8;
         default: return inssort_pkg::data_type'($urandom);
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(inssort_pkg::data_type v, logic l, logic t, sorted_rec_type w);
      while (!quiet_phase && $urandom_range(0, 99) < 10) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_value = v;
      req_last  = l;
      row_typed = t;
      row_want  = w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   initial begin
      int set_idx;
      int set_len;
      int sent;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].want);

      // hold off until the directed sets have fully drained
      req_valid = 1'b0;
      while (pending_sorted.size() != 0) @(negedge clock);

      set_idx = 0;
      sent    = 0;
      while (sent < RANDOM_ITEMS) begin
         unique case (set_idx)
            3:  set_len = inssort_pkg::CAPACITY;
            7:  set_len = inssort_pkg::CAPACITY + 1;
            12: set_len = inssort_pkg::CAPACITY + 3;
            default: set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                           : $urandom_range(1, 8);
         endcase
         quiet_phase = (set_idx >= 15 && set_idx < 25);
         for (int k = 0; k < set_len; k++)
            send_item(random_value(), k == set_len - 1, 1'b0, '0);
         sent += set_len;
         set_idx++;
      end
      quiet_phase = 1'b0;
      req_valid   = 1'b0;

      while (pending_sorted.size() != 0) @(posedge clock);
      repeat (inssort_pkg::CAPACITY + 8) @(posedge clock);
      if (error_count == 0)
         $display("[insertion_sorter] OK");
      else
         $display("[insertion_sorter] ERROR");
      $finish;
   end

   initial begin
      #2_400_000;
      $display("[insertion_sorter] ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/core/inssort_pkg.sv
rtl/core/inssort_cell.sv
rtl/core/insertion_sorter.sv
dv/insertion_sorter_test.sv
